// ===== rtl/kpc_pkg.sv =====
// ----------------------------------------------------------------------------
// kpc_pkg
// Types and constants shared by the key press classifier modules.
// ----------------------------------------------------------------------------
package kpc_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned THR_W   = 16;
    localparam int unsigned MASK_W  = 4;
    localparam int unsigned KEY_W   = 2;
    localparam int unsigned EVENT_W = 2;
    localparam int unsigned PHASE_W = 2;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    // key phase codes, one code left unused
    localparam logic [PHASE_W-1:0] PH_IDLE     = 2'd0;
    localparam logic [PHASE_W-1:0] PH_CONFIRM  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_PRESSING = 2'd2;

    // event codes
    localparam logic [EVENT_W-1:0] EV_NONE  = 2'd0;
    localparam logic [EVENT_W-1:0] EV_SHORT = 2'd1;
    localparam logic [EVENT_W-1:0] EV_LONG  = 2'd2;
    localparam logic [EVENT_W-1:0] EV_SUPER = 2'd3;

    // request codes
    localparam logic FUNC_POLL  = 1'b0;
    localparam logic FUNC_RESET = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LEVEL_MASK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TIME     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_TIME         = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SUPER_LONG_TIME   = 2'd3;

    // register reset values
    localparam logic [MASK_W-1:0] RST_ACTIVE_LEVEL_MASK = 4'd0;
    localparam logic [THR_W-1:0]  RST_DEBOUNCE_TIME     = 16'd20;
    localparam logic [THR_W-1:0]  RST_LONG_TIME         = 16'd1000;
    localparam logic [THR_W-1:0]  RST_SUPER_LONG_TIME   = 16'd3000;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [TIME_W-1:0]  press_start;
        logic               long_fired;
        logic               super_long_fired;
    } key_state_t;

    typedef struct packed {
        logic [THR_W-1:0] debounce_time;
        logic [THR_W-1:0] long_time;
        logic [THR_W-1:0] super_long_time;
    } thresholds_t;

    typedef struct packed {
        logic              func;
        logic [KEY_W-1:0]  key_index;
        logic              pin_level;
        logic [TIME_W-1:0] now_ms;
    } poll_t;

endpackage

// ===== rtl/kpc_if.sv =====
// ----------------------------------------------------------------------------
// kpc channel interfaces
// Valid/ready channels for key polls and classification results.
// ----------------------------------------------------------------------------
interface kpc_poll_if;
    import kpc_pkg::*;

    logic              valid;
    logic              ready;
    logic              func;
    logic [KEY_W-1:0]  key_index;
    logic              pin_level;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, func, key_index, pin_level, now_ms, input ready);
    modport sink   (input valid, func, key_index, pin_level, now_ms, output ready);
endinterface

interface kpc_result_if;
    import kpc_pkg::*;

    logic               valid;
    logic               ready;
    logic [EVENT_W-1:0] event_res;
    logic               idle;

    modport source (output valid, event_res, idle, input ready);
    modport sink   (input valid, event_res, idle, output ready);
endinterface

// ===== rtl/key_press_classifier.sv =====
// ----------------------------------------------------------------------------
// key_press_classifier
// Per-key debounce and short / long / super-long press classification.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  poll      in   valid/ready   func, key_index, pin_level, now_ms
//  result    out  valid/ready   event_res, idle
//  cfg_*     in   write enable  cfg_index, cfg_wdata
//
//  one poll is taken per cycle unless both registers are full and the result stalls;
//  key state is updated as a poll moves from the poll register to the result register
//  a poll in the register reads the state left by the one before it
//  rst_n clears all key state and loads the register defaults
//  a stalled result holds; the poll register still fills behind it
// ----------------------------------------------------------------------------
module key_press_classifier #(
    parameter int NUM_KEYS = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [kpc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [kpc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    kpc_poll_if.sink                            poll,
    kpc_result_if.source                        result
);
    import kpc_pkg::*;

    localparam int KEY_SEL_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    logic [MASK_W-1:0]    mask_reg;
    thresholds_t          thr_reg;

    poll_t                poll_reg;
    logic                 poll_valid_reg;
    logic                 poll_fire;

    key_state_t           key_state_reg [NUM_KEYS];
    key_state_t           cur_state;
    key_state_t           nxt_state;
    logic [KEY_SEL_W-1:0] key_sel;
    logic                 key_valid;
    logic                 pressed;
    logic [EVENT_W-1:0]   step_event;
    logic                 step_idle;

    logic                 result_valid_reg;
    logic [EVENT_W-1:0]   event_reg;
    logic                 idle_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg                <= RST_ACTIVE_LEVEL_MASK;
            thr_reg.debounce_time   <= RST_DEBOUNCE_TIME;
            thr_reg.long_time       <= RST_LONG_TIME;
            thr_reg.super_long_time <= RST_SUPER_LONG_TIME;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ACTIVE_LEVEL_MASK: mask_reg <= cfg_wdata[MASK_W-1:0];
                CFG_DEBOUNCE_TIME:     thr_reg.debounce_time   <= cfg_wdata[THR_W-1:0];
                CFG_LONG_TIME:         thr_reg.long_time       <= cfg_wdata[THR_W-1:0];
                CFG_SUPER_LONG_TIME:   thr_reg.super_long_time <= cfg_wdata[THR_W-1:0];
                default:               mask_reg <= mask_reg;
            endcase
        end
    end

    // poll register moves on when the result register is free or draining
    assign poll_fire  = poll_valid_reg && (!result_valid_reg || result.ready);
    assign poll.ready = !poll_valid_reg || poll_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_valid_reg <= 1'b0;
        end
        else if (poll.ready)
        begin
            poll_valid_reg <= poll.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (poll.valid && poll.ready)
        begin
            poll_reg.func      <= poll.func;
            poll_reg.key_index <= poll.key_index;
            poll_reg.pin_level <= poll.pin_level;
            poll_reg.now_ms    <= poll.now_ms;
        end
    end

    assign key_valid = int'(poll_reg.key_index) < NUM_KEYS;
    assign key_sel   = KEY_SEL_W'(poll_reg.key_index);
    assign cur_state = key_valid ? key_state_reg[key_sel] : '0;
    assign pressed   = (poll_reg.pin_level == mask_reg[poll_reg.key_index]);

    kpc_step u_step (
        .cur       (cur_state),
        .thr       (thr_reg),
        .func      (poll_reg.func),
        .pressed   (pressed),
        .now_ms    (poll_reg.now_ms),
        .nxt       (nxt_state),
        .event_res (step_event),
        .idle      (step_idle)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                key_state_reg[k] <= '0;
            end
        end
        else
        begin
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                if (poll_fire && key_valid && (key_sel == KEY_SEL_W'(k)))
                begin
                    key_state_reg[k] <= nxt_state;
                end
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (poll_fire)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (poll_fire)
        begin
            // unknown keys report no event and idle
            event_reg <= key_valid ? step_event : EV_NONE;
            idle_reg  <= key_valid ? step_idle : 1'b1;
        end
    end

    assign result.valid     = result_valid_reg;
    assign result.event_res = event_reg;
    assign result.idle      = idle_reg;

    // a reset request always reports an idle key with no event
    assert property (@(posedge clk) disable iff (!rst_n)
        poll_fire && (poll_reg.func == FUNC_RESET)
        |=> result_valid_reg && idle_reg && (event_reg == EV_NONE))
        else $error("reset request did not report idle");

    // an unknown key reports idle with no event
    assert property (@(posedge clk) disable iff (!rst_n)
        poll_fire && !key_valid
        |=> result_valid_reg && idle_reg && (event_reg == EV_NONE))
        else $error("unknown key changed the result");

    // long and super-long events leave the key held, short leaves it idle
    assert property (@(posedge clk) disable iff (!rst_n)
        poll_fire && key_valid && ((step_event == EV_LONG) || (step_event == EV_SUPER))
        |=> !idle_reg)
        else $error("long event reported an idle key");

    assert property (@(posedge clk) disable iff (!rst_n)
        poll_fire && key_valid && (step_event == EV_SHORT)
        |=> idle_reg)
        else $error("short event left key active");

    // back-pressure only when both stages are full and the result is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        !poll.ready |-> poll_valid_reg && result_valid_reg && !result.ready)
        else $error("poll stalled with free space");

endmodule

// ===== rtl/kpc_step.sv =====
// ----------------------------------------------------------------------------
// kpc_step
// Next-state and event logic for one poll or reset of one key.
// ----------------------------------------------------------------------------
module kpc_step (
    input  kpc_pkg::key_state_t            cur,
    input  kpc_pkg::thresholds_t           thr,
    input  logic                           func,
    input  logic                           pressed,
    input  logic [kpc_pkg::TIME_W-1:0]     now_ms,
    output kpc_pkg::key_state_t            nxt,
    output logic [kpc_pkg::EVENT_W-1:0]    event_res,
    output logic                           idle
);
    import kpc_pkg::*;

    logic [TIME_W-1:0] held;
    logic              debounce_met;
    logic              long_met;
    logic              super_met;

    // elapsed time wraps modulo 2^32
    assign held         = now_ms - cur.press_start;
    assign debounce_met = held >= {{(TIME_W-THR_W){1'b0}}, thr.debounce_time};
    assign long_met     = held >= {{(TIME_W-THR_W){1'b0}}, thr.long_time};
    assign super_met    = held >= {{(TIME_W-THR_W){1'b0}}, thr.super_long_time};

    always_comb
    begin
        nxt       = cur;
        event_res = EV_NONE;
        if (func == FUNC_RESET)
        begin
            nxt.phase            = PH_IDLE;
            nxt.press_start      = '0;
            nxt.long_fired       = 1'b0;
            nxt.super_long_fired = 1'b0;
        end
        else
        begin
            unique case (cur.phase)
                PH_IDLE:
                begin
                    if (pressed)
                    begin
                        nxt.press_start = now_ms;
                        nxt.phase       = PH_CONFIRM;
                    end
                end
                PH_CONFIRM:
                begin
                    if (!pressed)
                    begin
                        nxt.phase = PH_IDLE;
                    end
                    else if (debounce_met)
                    begin
                        nxt.phase            = PH_PRESSING;
                        nxt.long_fired       = 1'b0;
                        nxt.super_long_fired = 1'b0;
                    end
                end
                PH_PRESSING:
                begin
                    if (pressed)
                    begin
                        // at most one event per poll, long first
                        priority if (!cur.long_fired && long_met)
                        begin
                            nxt.long_fired = 1'b1;
                            event_res      = EV_LONG;
                        end
                        else if (!cur.super_long_fired && super_met)
                        begin
                            nxt.super_long_fired = 1'b1;
                            event_res            = EV_SUPER;
                        end
                    end
                    else
                    begin
                        if (!cur.long_fired && !cur.super_long_fired)
                        begin
                            event_res = EV_SHORT;
                        end
                        nxt.phase = PH_IDLE;
                    end
                end
                default:
                begin
                    nxt = cur;
                end
            endcase
        end
    end

    assign idle = (nxt.phase == PH_IDLE);

endmodule
